>>> design/sswf_pkg.sv
`default_nettype none
package sswf_pkg;

    localparam int DATA_W  = 8;
    localparam int IN_W    = 64;
    localparam int PAY_N   = 6;
    localparam int STEP_W  = 4;

    localparam logic [DATA_W-1:0] HDR_BYTE   = 8'hFF;
    localparam logic [DATA_W-1:0] BCAST_ID   = 8'hFE;
    localparam logic [DATA_W-1:0] INSTR_RST  = 8'h83;

    localparam logic [STEP_W-1:0] STEP_HDR0  = 4'd0;
    localparam logic [STEP_W-1:0] STEP_HDR1  = 4'd1;
    localparam logic [STEP_W-1:0] STEP_ID    = 4'd2;
    localparam logic [STEP_W-1:0] STEP_LEN   = 4'd3;
    localparam logic [STEP_W-1:0] STEP_INSTR = 4'd4;
    localparam logic [STEP_W-1:0] STEP_ADDR  = 4'd5;
    localparam logic [STEP_W-1:0] STEP_NB    = 4'd6;

    typedef logic [PAY_N-1:0][DATA_W-1:0] t_pay;

    typedef struct packed {
        logic [STEP_W-1:0] len;
        logic [STEP_W-1:0] last_step;
        logic              two_bytes;
        logic [DATA_W-1:0] addr;
        t_pay              pay;
    } t_req;

endpackage
`default_nettype wire

>>> design/servo_sync_write_packet_framer.sv
// A request reaches m_axis via queue, serializer state and output register.
// Throughput: one byte per cycle unless m_axis_tready stalls; packets are 10 to 14
// bytes (len + 4) from the back-end serializer; a 2-entry request queue lets
// the next request be taken while the current packet is sent.
// Reset: synchronous, active low; clears queue and serializer, instruction = 0x83.
`default_nettype none
module servo_sync_write_packet_framer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [1:0] servo_count, [3:2] bytes_per_servo, [11:4] start_address,
    // [19:12] first_id, [27:20] first_byte_a, [35:28] first_byte_b,
    // [43:36] second_id, [51:44] second_byte_a, [59:52] second_byte_b, [63:60] zero
    input  wire logic [63:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [7:0] tx_byte
    output logic [7:0]       m_axis_tdata,
    output logic             m_axis_tlast,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [7:0]  i_cfg_wr_data
);
    import sswf_pkg::*;

    logic [DATA_W-1:0] r_instr;
    logic              push;
    logic              full;
    logic              q_valid;
    logic              pop;
    t_req              req_in;
    t_req              req_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_instr <= INSTR_RST;
        end else if (i_cfg_wr_en) begin
            r_instr <= i_cfg_wr_data;
        end
    end

    sswf_front u_front (
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (s_axis_tdata),
        .i_full  (full),
        .o_push  (push),
        .o_req   (req_in)
    );

    sswf_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (req_in),
        .o_full  (full),
        .o_valid (q_valid),
        .o_data  (req_out),
        .i_pop   (pop)
    );

    sswf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_instr     (r_instr),
        .i_req_valid (q_valid),
        .i_req       (req_out),
        .o_pop       (pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_byte      (m_axis_tdata),
        .o_last      (m_axis_tlast)
    );

endmodule
`default_nettype wire

>>> design/sswf_front.sv
`default_nettype none
module sswf_front (
    input  wire logic                    i_valid,
    output logic                         o_ready,
    input  wire logic [sswf_pkg::IN_W-1:0] i_data,
    input  wire logic                    i_full,
    output logic                         o_push,
    output sswf_pkg::t_req               o_req
);
    import sswf_pkg::*;

    logic [1:0]        cnt_raw;
    logic [1:0]        nb_raw;
    logic              two_servos;
    logic              two_bytes;
    logic [DATA_W-1:0] id0, a0, b0, id1, a1, b1;

    assign cnt_raw    = i_data[1:0];
    assign nb_raw     = i_data[3:2];
    assign two_servos = cnt_raw[1];
    assign two_bytes  = nb_raw[1];
    assign id0        = i_data[19:12];
    assign a0         = i_data[27:20];
    assign b0         = i_data[35:28];
    assign id1        = i_data[43:36];
    assign a1         = i_data[51:44];
    assign b1         = i_data[59:52];

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    always_comb begin
        o_req.addr      = i_data[11:4];
        o_req.two_bytes = two_bytes;
        unique case ({two_servos, two_bytes})
            2'b00: o_req.len = 4'd6;
            2'b01: o_req.len = 4'd7;
            2'b10: o_req.len = 4'd8;
            2'b11: o_req.len = 4'd10;
            default: o_req.len = 4'd6;
        endcase
        o_req.last_step = o_req.len + 4'd3;
        if (two_bytes) begin
            o_req.pay = {b1, a1, id1, b0, a0, id0};
        end else begin
            o_req.pay = {8'h00, 8'h00, a1, id1, a0, id0};
        end
    end

endmodule
`default_nettype wire

>>> design/sswf_fifo.sv
`default_nettype none
module sswf_fifo (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire sswf_pkg::t_req i_data,
    output logic                o_full,
    output logic                o_valid,
    output sswf_pkg::t_req      o_data,
    input  wire logic           i_pop
);
    import sswf_pkg::*;

    t_req       r_mem [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count, n_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr ^ i_push;
        n_rd_ptr = r_rd_ptr ^ i_pop;
        n_count  = r_count + {1'b0, i_push} - {1'b0, i_pop};
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule
`default_nettype wire

>>> design/sswf_back.sv
`default_nettype none
module sswf_back (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic [sswf_pkg::DATA_W-1:0] i_instr,
    input  wire logic                       i_req_valid,
    input  wire sswf_pkg::t_req             i_req,
    output logic                            o_pop,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output logic [sswf_pkg::DATA_W-1:0]     o_byte,
    output logic                            o_last
);
    import sswf_pkg::*;

    logic              r_busy;
    logic [STEP_W-1:0] r_step;
    t_req              r_req;
    logic [DATA_W-1:0] r_sum;
    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_byte;
    logic              r_out_last;

    logic              out_adv;
    logic              emit;
    logic              at_last;
    logic              free;
    logic              load;
    logic [DATA_W-1:0] cur_byte;

    assign out_adv = !r_out_valid || i_ready;
    assign emit    = r_busy && out_adv;
    assign at_last = (r_step == r_req.last_step);
    assign free    = !r_busy || (emit && at_last);
    assign load    = free && i_req_valid;
    assign o_pop   = load;

    assign o_valid = r_out_valid;
    assign o_byte  = r_out_byte;
    assign o_last  = r_out_last;

    always_comb begin
        priority if (at_last) begin
            cur_byte = ~r_sum;
        end else begin
            unique case (r_step)
                STEP_HDR0:  cur_byte = HDR_BYTE;
                STEP_HDR1:  cur_byte = HDR_BYTE;
                STEP_ID:    cur_byte = BCAST_ID;
                STEP_LEN:   cur_byte = {{(DATA_W-STEP_W){1'b0}}, r_req.len};
                STEP_INSTR: cur_byte = i_instr;
                STEP_ADDR:  cur_byte = r_req.addr;
                STEP_NB:    cur_byte = r_req.two_bytes ? 8'd2 : 8'd1;
                default:    cur_byte = r_req.pay[0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_req <= i_req;
            r_sum <= '0;
        end else if (emit) begin
            if (r_step >= STEP_ID) begin
                r_sum <= r_sum + cur_byte;
            end
            if (r_step > STEP_NB) begin
                r_req.pay <= {8'h00, r_req.pay[PAY_N-1:1]};
            end
        end
        if (out_adv) begin
            r_out_byte <= cur_byte;
            r_out_last <= at_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (emit) begin
                if (at_last) begin
                    r_busy <= 1'b0;
                end
                r_step <= r_step + 4'd1;
            end
            if (out_adv) begin
                r_out_valid <= r_busy;
            end
        end
    end

endmodule
`default_nettype wire
